[sv/crsf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_pkg: shared types and constants
// Register indexes, reset values, the frame length limit and the result beat
// layout for the CRSF frame parser.
// ----------------------------------------------------------------------------
package crsf_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 7;
	localparam int unsigned CIDX_W  = 2;
	localparam int unsigned ODATA_W = 16;
	localparam int unsigned OUSER_W = 2;

	localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hC8;
	localparam logic [BYTE_W-1:0] POLY_RESET   = 8'hD5;
	localparam logic [BYTE_W-1:0] LENGTH_LIMIT = 8'd64;
	localparam logic [BYTE_W-1:0] LENGTH_MIN   = 8'd2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_SYNC = 2'd0;
	localparam logic [CIDX_W-1:0] REG_POLY = 2'd1;

	typedef struct packed {
		logic [LEN_W-1:0]  frame_length;
		logic              crc_good;
		logic              last;
		logic              is_type;
		logic [BYTE_W-1:0] byte_value;
	} out_beat_t;

endpackage : crsf_pkg
`default_nettype wire

[sv/crsf_crc8.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_crc8: one-byte CRC-8 update
// MSB-first CRC-8 over one byte with a programmable polynomial, no final XOR.
// ----------------------------------------------------------------------------
module crsf_crc8
	import crsf_pkg::*;
(
	input  wire logic [BYTE_W-1:0] crc_in,
	input  wire logic [BYTE_W-1:0] data,
	input  wire logic [BYTE_W-1:0] poly,
	output      logic [BYTE_W-1:0] crc_out
);

	always_comb begin
		logic [BYTE_W-1:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ poly;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule : crsf_crc8
`default_nettype wire

[sv/crsf_fsm.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_fsm: frame tracking and result register
// Hunt / length / type / body sequencing, running CRC, and the output
// register that holds one result beat.
// ----------------------------------------------------------------------------
module crsf_fsm
	import crsf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,      // process byte_in this cycle
	input  wire logic              out_free,  // result register may load
	input  wire logic [BYTE_W-1:0] byte_in,
	input  wire logic [BYTE_W-1:0] sync_value,
	input  wire logic [BYTE_W-1:0] crc_poly,
	output      logic              res_valid_q,
	output      out_beat_t         res_q
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LENGTH,
		PH_TYPE,
		PH_BODY
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  left_q, left_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0] crc_q, crc_d;
	logic [BYTE_W-1:0] crc_seed, crc_next;
	logic              emit;
	out_beat_t         res_d;

	assign crc_seed = (phase_q == PH_TYPE) ? '0 : crc_q;

	crsf_crc8 u_crc (
		.crc_in  (crc_seed),
		.data    (byte_in),
		.poly    (crc_poly),
		.crc_out (crc_next)
	);

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		len_d   = len_q;
		crc_d   = crc_q;
		emit    = 1'b0;
		res_d.byte_value   = byte_in;
		res_d.is_type      = 1'b0;
		res_d.last         = 1'b0;
		res_d.crc_good     = 1'b0;
		res_d.frame_length = len_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_in == sync_value) phase_d = PH_LENGTH;
			end
			PH_LENGTH: begin
				// a repeated sync restarts the length wait
				if (byte_in != sync_value) begin
					if (byte_in < LENGTH_MIN || byte_in > LENGTH_LIMIT) begin
						len_d   = '0;
						phase_d = PH_HUNT;
					end else begin
						len_d   = byte_in[LEN_W-1:0];
						left_d  = byte_in[LEN_W-1:0];
						phase_d = PH_TYPE;
					end
				end
			end
			PH_TYPE: begin
				crc_d         = crc_next;
				left_d        = left_q - LEN_W'(1);
				phase_d       = PH_BODY;
				emit          = 1'b1;
				res_d.is_type = 1'b1;
			end
			PH_BODY: begin
				emit = 1'b1;
				if (left_q <= LEN_W'(1)) begin
					res_d.last     = 1'b1;
					res_d.crc_good = (byte_in == crc_q);
					left_d         = '0;
					crc_d          = '0;
					phase_d        = PH_HUNT;
				end else begin
					crc_d  = crc_next;
					left_d = left_q - LEN_W'(1);
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			left_q      <= '0;
			len_q       <= '0;
			crc_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				left_q  <= left_d;
				len_q   <= len_d;
				crc_q   <= crc_d;
			end
			if (out_free) begin
				res_valid_q <= step && emit;
				res_q       <= res_d;
			end
		end
	end

endmodule : crsf_fsm
`default_nettype wire

[sv/crsf_frame_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_frame_parser: CRSF serial frame receiver
// Finds sync and length, forwards type and payload bytes and closes each
// frame with a last beat carrying the received CRC and its check result.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_*     | in  | tdata[7:0] rx_byte
//  m_*     | out | tdata[7:0] byte_value, [14:8] frame_length, [15] zero;
//          |     | tuser[0] is_type, [1] crc_good; tlast last
//  cfg_*   | in  | idx 0 sync_value, idx 1 crc_poly, others ignored
//
//  One byte per cycle sustained while m_tready is high; each s beat passes the
//  input register, then the frame logic into the result register.
//  Sync, length and rejected bytes produce no m beat.
//  A stalled m side backs up through the input register to s_tready.
//  Reset: hunting for sync, registers at 0xC8 / 0xD5.
// ----------------------------------------------------------------------------
module crsf_frame_parser
	import crsf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output      logic               s_tready,
	input  wire logic [BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
	output      logic               m_tvalid,
	input  wire logic               m_tready,
	output      logic [ODATA_W-1:0] m_tdata,   // [7:0] byte_value, [14:8] frame_length
	output      logic [OUSER_W-1:0] m_tuser,   // [0] is_type, [1] crc_good
	output      logic               m_tlast,
	input  wire logic               cfg_we,
	input  wire logic [CIDX_W-1:0]  cfg_index,
	input  wire logic [BYTE_W-1:0]  cfg_data
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [BYTE_W-1:0] sync_q, poly_q;
	logic              out_free, step;
	out_beat_t         res;

	assign out_free = !m_tvalid || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
			poly_q <= POLY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC: sync_q <= cfg_data;
				REG_POLY: poly_q <= cfg_data;
				default: ;
			endcase
		end
	end

	crsf_fsm u_fsm (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.out_free    (out_free),
		.byte_in     (byte_s1),
		.sync_value  (sync_q),
		.crc_poly    (poly_q),
		.res_valid_q (m_tvalid),
		.res_q       (res)
	);

	assign m_tdata = {1'b0, res.frame_length, res.byte_value};
	assign m_tuser = {res.crc_good, res.is_type};
	assign m_tlast = res.last;

endmodule : crsf_frame_parser
`default_nettype wire

[sv/crsf_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crsf_chk: port-level checks for the frame parser
// Watches the result stream for beat field consistency.
// ----------------------------------------------------------------------------
module crsf_chk
	import crsf_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic [ODATA_W-1:0] m_tdata,
	input wire logic [OUSER_W-1:0] m_tuser,
	input wire logic               m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("m beat changed while stalled");

	a_good_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("crc_good set on a non-last beat");

	a_type_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tlast)
		else $error("type beat marked last");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({1'b0, m_tdata[14:8]} >= LENGTH_MIN)
			&& ({1'b0, m_tdata[14:8]} <= LENGTH_LIMIT))
		else $error("frame_length out of range on an m beat");

endmodule : crsf_chk

bind crsf_frame_parser crsf_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
